// ===== sv/pmsfa_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// PM sensor frame averager package
// Shared constants, codes and the sequencer state type.
// ----------------------------------------------------------------------------
package pmsfa_pkg;

  // Default sizes handed to the top level
  localparam int FRAME_LEN_DEF  = 24;
  localparam int COUNT_BITS_DEF = 16;

  // Fixed field widths
  localparam int READ_W    = 16;  // one PM reading
  localparam int FRAC_W    = 8;   // fraction bits of an average
  localparam int AVG_W     = READ_W + FRAC_W;
  localparam int BCNT_W    = 6;   // received byte count, saturating
  localparam int OFF_W     = 5;
  localparam int TICKS_W   = 16;
  localparam int CFG_W     = 16;
  localparam int CFG_IDX_W = 2;

  localparam logic [BCNT_W-1:0] BCNT_MAX = '1;

  // Frame header bytes
  localparam logic [7:0] HDR0 = 8'h42;  // 'B'
  localparam logic [7:0] HDR1 = 8'h4D;  // 'M'

  // Operation codes of an input item
  localparam logic [1:0] OP_BYTE = 2'd0;
  localparam logic [1:0] OP_POLL = 2'd1;
  localparam logic [1:0] OP_TICK = 2'd2;

  // Result kinds
  localparam logic KIND_FRAME = 1'b0;
  localparam logic KIND_POLL  = 1'b1;

  // Frame status codes
  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_LEN_ERR = 2'd1;
  localparam logic [1:0] ST_HDR_ERR = 2'd2;
  localparam logic [1:0] ST_SUM_ERR = 2'd3;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_PM1_OFF  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_PM25_OFF = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_PM10_OFF = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_TIMEOUT  = 2'd3;

  // Configuration reset values
  localparam logic [OFF_W-1:0]   PM1_OFF_RST  = 5'd4;
  localparam logic [OFF_W-1:0]   PM25_OFF_RST = 5'd6;
  localparam logic [OFF_W-1:0]   PM10_OFF_RST = 5'd8;
  localparam logic [TICKS_W-1:0] TICKS_RST    = 16'd5000;

  // Reading fetch: three readings of two bytes each
  localparam int FETCH_LAST = 5;
  localparam int NUM_PM     = 3;

  typedef enum logic [3:0] {
    S_IDLE,
    S_SWEEP,
    S_DRAIN,
    S_EVAL,
    S_FETCH,
    S_FDRAIN,
    S_DIVGO,
    S_DIVWAIT,
    S_DONE
  } state_e;

endpackage

// ===== sv/pmsfa_ram.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Generic RAM
// One write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module pmsfa_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 32,
  localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  // Write and registered read
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

// ===== sv/pmsfa_div.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Serial divider
// Restoring division, one quotient bit a cycle, of (sum << 8) by the count.
// The quotient is known to fit in 16.8, so only its low bits are formed.
// ----------------------------------------------------------------------------
module pmsfa_div
  import pmsfa_pkg::*;
#(
  parameter int COUNT_BITS = COUNT_BITS_DEF,
  localparam int SUM_W     = READ_W + COUNT_BITS
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  start_i,
  input  logic [SUM_W-1:0]      dividend_i,
  input  logic [COUNT_BITS-1:0] divisor_i,
  output logic [AVG_W-1:0]      quotient_o,
  output logic                  done_o
);

  localparam int STEP_W = $clog2(AVG_W + 1);

  logic                  busy_q;
  logic                  done_q;
  logic [STEP_W-1:0]     step_q;
  logic [COUNT_BITS-1:0] rem_q;
  logic [COUNT_BITS-1:0] divisor_q;
  logic [AVG_W-1:0]      sh_q;
  logic [COUNT_BITS:0]   trial;
  logic [COUNT_BITS:0]   diff;
  logic                  ge;

  // Trial subtract of the shifted remainder
  always_comb begin
    trial = {rem_q, sh_q[AVG_W-1]};
    diff  = trial - {1'b0, divisor_q};
    ge    = ~diff[COUNT_BITS];
  end

  // Control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
      end else if (busy_q && step_q == STEP_W'(1)) begin
        busy_q <= 1'b0;
        done_q <= 1'b1;
      end
    end
  end

  // Remainder and quotient shift register
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q     <= dividend_i[SUM_W-1:READ_W];
      sh_q      <= {dividend_i[READ_W-1:0], FRAC_W'(0)};
      divisor_q <= divisor_i;
      step_q    <= STEP_W'(AVG_W);
    end else if (busy_q) begin
      rem_q  <= ge ? diff[COUNT_BITS-1:0] : trial[COUNT_BITS-1:0];
      sh_q   <= {sh_q[AVG_W-2:0], ge};
      step_q <= step_q - STEP_W'(1);
    end
  end

  assign quotient_o = sh_q;
  assign done_o     = done_q;

endmodule

// ===== sv/pm_sensor_frame_averager.sv =====
`timescale 1ns / 1ps
// Sequence: a byte or a tick leaves the sequencer in S_IDLE. A chunk end goes to S_DONE
// on a bad length; otherwise it sweeps the buffer (S_SWEEP, S_DRAIN, S_EVAL), and on a
// good frame below a full count it then adds the readings (six reading bytes, S_FETCH).
// A poll runs the serial divider on each reading in turn; an empty poll goes to S_DONE.
// One item at a time; a waiting result does not block the next item.
// Reset clears sums, count and byte count, loads the timer and config defaults.
// ----------------------------------------------------------------------------
// PM sensor frame averager
// Checks sensor frames from received bytes, sums the PM readings of good
// frames and returns the 16.8 averages on a poll.
// ----------------------------------------------------------------------------
module pm_sensor_frame_averager
  import pmsfa_pkg::*;
#(
  parameter int FRAME_LEN  = FRAME_LEN_DEF,
  parameter int COUNT_BITS = COUNT_BITS_DEF
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  // input items
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  input  logic [1:0]           op_i,
  input  logic [7:0]           rx_byte_i,
  input  logic                 chunk_end_i,
  // result items
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output logic                 kind_o,
  output logic [1:0]           frame_status_o,
  output logic                 avg_valid_o,
  output logic [AVG_W-1:0]     pm1_avg_o,
  output logic [AVG_W-1:0]     pm25_avg_o,
  output logic [AVG_W-1:0]     pm10_avg_o,
  // configuration
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_index_i,
  input  logic [CFG_W-1:0]     cfg_wdata_i
);

  localparam int AW    = $clog2(FRAME_LEN);
  localparam int SEQ_W = (AW > 3) ? AW : 3;
  localparam int SUM_W = READ_W + COUNT_BITS;

  localparam logic [COUNT_BITS-1:0] COUNT_MAX = '1;

  // Configuration
  logic [OFF_W-1:0]   pm1_off_q, pm25_off_q, pm10_off_q;
  logic [TICKS_W-1:0] timeout_ticks_q;

  // Sequencer and accumulator state
  state_e                state_q, state_d;
  logic [SEQ_W-1:0]      cnt_q;
  logic [BCNT_W-1:0]     byte_count_q;
  logic [BCNT_W-1:0]     bcnt_inc;
  logic [SUM_W-1:0]      sums_q [NUM_PM];
  logic [COUNT_BITS-1:0] sample_total_q;
  logic [TICKS_W-1:0]    timeout_left_q;
  logic                  timer_running_q;

  // Read pipeline and check registers
  logic                  pipe_vld_q;
  logic                  pipe_fetch_q;
  logic                  pipe_rng_q;
  logic [SEQ_W-1:0]      pipe_step_q;
  logic [7:0]            rdata;
  logic [7:0]            byte_v;
  logic [READ_W-1:0]     csum_q;
  logic [READ_W-1:0]     want_q;
  logic                  hdr_bad_q;
  logic [7:0]            hi_q;

  // Result registers
  logic                  res_kind_q;
  logic [1:0]            res_status_q;
  logic                  res_avg_valid_q;
  logic [AVG_W-1:0]      avg_q [NUM_PM];
  logic                  out_valid_q;
  logic                  out_kind_q;
  logic [1:0]            out_status_q;
  logic                  out_avg_valid_q;
  logic [AVG_W-1:0]      out_avg_q [NUM_PM];

  // Control from the sequencer
  logic                  accept;
  logic                  ram_we;
  logic [AW-1:0]         raddr;
  logic                  issue;
  logic                  issue_fetch;
  logic                  issue_rng;
  logic [OFF_W-1:0]      off_sel;
  logic [OFF_W:0]        fetch_idx;
  logic                  frame_good;
  logic                  div_start;
  logic                  out_load;
  logic [1:0]            div_k;
  logic [AVG_W-1:0]      quotient;
  logic                  div_done;

  assign accept     = in_valid_i && (state_q == S_IDLE);
  assign in_stall_o = (state_q != S_IDLE);
  assign bcnt_inc   = (byte_count_q < BCNT_MAX) ? byte_count_q + BCNT_W'(1) : byte_count_q;
  assign ram_we     = accept && (op_i == OP_BYTE) && (byte_count_q < BCNT_W'(FRAME_LEN));
  assign div_k      = cnt_q[1:0];
  assign frame_good = !hdr_bad_q && (csum_q == want_q);

  // Frame buffer
  pmsfa_ram #(
    .WIDTH (8),
    .DEPTH (FRAME_LEN)
  ) u_frame_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (byte_count_q[AW-1:0]),
    .wdata_i (rx_byte_i),
    .raddr_i (raddr),
    .rdata_o (rdata)
  );

  // Shared divider
  pmsfa_div #(
    .COUNT_BITS (COUNT_BITS)
  ) u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (sums_q[div_k]),
    .divisor_i  (sample_total_q),
    .quotient_o (quotient),
    .done_o     (div_done)
  );

  // Next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: begin
        if (accept) begin
          if (op_i == OP_BYTE && chunk_end_i) begin
            state_d = (bcnt_inc == BCNT_W'(FRAME_LEN)) ? S_SWEEP : S_DONE;
          end else if (op_i == OP_POLL) begin
            state_d = (sample_total_q == '0) ? S_DONE : S_DIVGO;
          end
        end
      end
      S_SWEEP: begin
        if (cnt_q == SEQ_W'(FRAME_LEN - 1)) state_d = S_DRAIN;
      end
      S_DRAIN: state_d = S_EVAL;
      S_EVAL: begin
        if (frame_good && sample_total_q != COUNT_MAX) state_d = S_FETCH;
        else state_d = S_DONE;
      end
      S_FETCH: begin
        if (cnt_q == SEQ_W'(FETCH_LAST)) state_d = S_FDRAIN;
      end
      S_FDRAIN: state_d = S_DONE;
      S_DIVGO:  state_d = S_DIVWAIT;
      S_DIVWAIT: begin
        if (div_done) state_d = (div_k == 2'(NUM_PM - 1)) ? S_DONE : S_DIVGO;
      end
      S_DONE: begin
        if (out_load) state_d = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  // Sequencer outputs
  always_comb begin
    unique case (cnt_q[2:1])
      2'd0:    off_sel = pm1_off_q;
      2'd1:    off_sel = pm25_off_q;
      default: off_sel = pm10_off_q;
    endcase
    fetch_idx   = {1'b0, off_sel} + (OFF_W + 1)'(cnt_q[0]);
    issue_rng   = fetch_idx < (OFF_W + 1)'(FRAME_LEN);
    issue       = (state_q == S_SWEEP) || (state_q == S_FETCH);
    issue_fetch = (state_q == S_FETCH);
    raddr       = issue_fetch ? fetch_idx[AW-1:0] : cnt_q[AW-1:0];
    div_start   = (state_q == S_DIVGO);
    out_load    = (state_q == S_DONE) && (!out_valid_q || !out_stall_i);
  end

  // Byte read back from the buffer; an index beyond the frame reads as zero
  assign byte_v = (pipe_fetch_q && !pipe_rng_q) ? 8'h00 : rdata;

  // Control state, sums, timer and configuration
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q         <= S_IDLE;
      cnt_q           <= '0;
      byte_count_q    <= '0;
      sums_q          <= '{default: '0};
      sample_total_q  <= '0;
      timeout_left_q  <= TICKS_RST;
      timer_running_q <= 1'b1;
      pipe_vld_q      <= 1'b0;
      out_valid_q     <= 1'b0;
      pm1_off_q       <= PM1_OFF_RST;
      pm25_off_q      <= PM25_OFF_RST;
      pm10_off_q      <= PM10_OFF_RST;
      timeout_ticks_q <= TICKS_RST;
    end else begin
      state_q    <= state_d;
      pipe_vld_q <= issue;

      // Write configuration
      if (cfg_we_i) begin
        unique case (cfg_index_i)
          CFG_PM1_OFF:  pm1_off_q       <= cfg_wdata_i[OFF_W-1:0];
          CFG_PM25_OFF: pm25_off_q      <= cfg_wdata_i[OFF_W-1:0];
          CFG_PM10_OFF: pm10_off_q      <= cfg_wdata_i[OFF_W-1:0];
          CFG_TIMEOUT:  timeout_ticks_q <= cfg_wdata_i[TICKS_W-1:0];
          default: ;
        endcase
      end

      // Advance the step counter
      if (state_q == S_IDLE || state_q == S_EVAL) begin
        cnt_q <= '0;
      end else if (issue || (state_q == S_DIVWAIT && div_done)) begin
        cnt_q <= cnt_q + SEQ_W'(1);
      end

      // Count received bytes; restart at every chunk end
      if (accept && op_i == OP_BYTE) begin
        byte_count_q <= chunk_end_i ? '0 : bcnt_inc;
      end

      // Run the timeout on a tick; at expiry clear the sums and the count
      if (accept && op_i == OP_TICK && timer_running_q) begin
        if (timeout_left_q <= TICKS_W'(1)) begin
          timeout_left_q  <= '0;
          timer_running_q <= 1'b0;
          sums_q          <= '{default: '0};
          sample_total_q  <= '0;
        end else begin
          timeout_left_q <= timeout_left_q - TICKS_W'(1);
        end
      end

      // Restart the timeout on a good frame
      if (state_q == S_EVAL && frame_good) begin
        timeout_left_q  <= timeout_ticks_q;
        timer_running_q <= 1'b1;
      end

      // Add a reading as its low byte arrives
      if (pipe_vld_q && pipe_fetch_q && pipe_step_q[0]) begin
        sums_q[pipe_step_q[2:1]] <= sums_q[pipe_step_q[2:1]] + SUM_W'({hi_q, byte_v});
      end
      if (state_q == S_FDRAIN) begin
        sample_total_q <= sample_total_q + COUNT_BITS'(1);
      end

      // Clear the sums once the last average is taken
      if (state_q == S_DIVWAIT && div_done && div_k == 2'(NUM_PM - 1)) begin
        sums_q         <= '{default: '0};
        sample_total_q <= '0;
      end

      // Hold a result until it is taken
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Check registers, read pipeline and result payload
  always_ff @(posedge clk_i) begin
    pipe_fetch_q <= issue_fetch;
    pipe_rng_q   <= issue_rng;
    pipe_step_q  <= cnt_q;

    if (accept && op_i == OP_BYTE && chunk_end_i) begin
      csum_q          <= '0;
      hdr_bad_q       <= 1'b0;
      res_kind_q      <= KIND_FRAME;
      res_status_q    <= ST_LEN_ERR;
      res_avg_valid_q <= 1'b0;
    end

    if (accept && op_i == OP_POLL) begin
      res_kind_q      <= KIND_POLL;
      res_status_q    <= ST_OK;
      res_avg_valid_q <= (sample_total_q != '0);
    end

    // Sweep the buffer: header, checksum and expected sum
    if (pipe_vld_q && !pipe_fetch_q) begin
      if (pipe_step_q == SEQ_W'(0) && byte_v != HDR0) hdr_bad_q <= 1'b1;
      if (pipe_step_q == SEQ_W'(1) && byte_v != HDR1) hdr_bad_q <= 1'b1;
      if (pipe_step_q < SEQ_W'(FRAME_LEN - 2)) begin
        csum_q <= csum_q + READ_W'(byte_v);
      end
      if (pipe_step_q == SEQ_W'(FRAME_LEN - 2)) want_q[15:8] <= byte_v;
      if (pipe_step_q == SEQ_W'(FRAME_LEN - 1)) want_q[7:0]  <= byte_v;
    end

    // Hold the high byte of a reading
    if (pipe_vld_q && pipe_fetch_q && !pipe_step_q[0]) begin
      hi_q <= byte_v;
    end

    if (state_q == S_EVAL) begin
      priority if (hdr_bad_q) res_status_q <= ST_HDR_ERR;
      else if (csum_q != want_q) res_status_q <= ST_SUM_ERR;
      else res_status_q <= ST_OK;
    end

    if (state_q == S_DIVWAIT && div_done) begin
      avg_q[div_k] <= quotient;
    end

    if (out_load) begin
      out_kind_q      <= res_kind_q;
      out_status_q    <= res_status_q;
      out_avg_valid_q <= res_avg_valid_q;
      for (int k = 0; k < NUM_PM; k++) begin
        out_avg_q[k] <= res_avg_valid_q ? avg_q[k] : '0;
      end
    end
  end

  assign out_valid_o    = out_valid_q;
  assign kind_o         = out_kind_q;
  assign frame_status_o = out_status_q;
  assign avg_valid_o    = out_avg_valid_q;
  assign pm1_avg_o      = out_avg_q[0];
  assign pm25_avg_o     = out_avg_q[1];
  assign pm10_avg_o     = out_avg_q[2];

endmodule
